### src/rsd_pkg.sv
// Package for the distinct rank sorter: payload types, state codes and defaults.
package rsd_pkg;

  localparam int unsigned DataW        = 16;
  localparam int unsigned MaxItemsDflt = 16;

  typedef struct packed {
    logic signed [DataW-1:0] sample;
    logic                    final_item;
  } rsd_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    last_out;
  } rsd_out_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RDI,
    S_LATI,
    S_CMP,
    S_WR,
    S_SRD,
    S_SGET,
    S_FLUSH
  } rsd_state_e;

endpackage

### src/rsd_ram.sv
// Generic single write port, single read port RAM with registered read data.
module rsd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/rank_sort_distinct.sv
// Top level of the distinct rank sorter: sequencer, shared comparator and output stage.
//
// Usage: a set of signed 16-bit samples arrives on the input channel, one per
// request, and the request with final_item set closes the set. Up to MAX_ITEMS
// samples are kept; later samples of the same set are dropped, but the final
// mark still closes the set. The block then ranks every stored sample against
// all others with one comparator and writes it to the slot at its rank, so equal
// samples land in one slot. The occupied slots leave on the output channel in
// ascending order, with last_out set on the largest value.
// The input stays ready while the set loads. Ranking then takes one stored sample
// at a time: it reads it from the value memory, compares it with every stored
// sample at one compare per cycle, and writes it to the slot at its rank. The
// slot scan then visits every slot in order, from the lowest slot upwards.
// The input is not ready from the final request until the last result has
// been placed in the output register.
// A stalled receiver holds the scan; the result in the output register stays
// until taken. Reset empties the set, clears all slot valid bits and drops any
// pending result.
module rank_sort_distinct #(
  parameter int unsigned MAX_ITEMS = rsd_pkg::MaxItemsDflt
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rsd_pkg::rsd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rsd_pkg::rsd_out_t out_data_o
);

  import rsd_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_ITEMS);
  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  rsd_state_e state_q, state_d;

  logic [CntW-1:0]         cnt_q;
  logic [IdxW-1:0]         i_q;
  logic [CntW-1:0]         j_q;
  logic [IdxW-1:0]         rank_q;
  logic [IdxW-1:0]         s_q;
  logic signed [DataW-1:0] vi_q;
  logic [MAX_ITEMS-1:0]    slot_valid_q;
  logic signed [DataW-1:0] pend_q;
  logic                    pend_v_q;
  rsd_out_t                out_q;
  logic                    out_valid_q;

  logic             in_acc;
  logic             store_ok;
  logic             val_we;
  logic [IdxW-1:0]  val_raddr;
  logic [DataW-1:0] val_rdata;
  logic             slot_we;
  logic [DataW-1:0] slot_rdata;
  logic             out_free;
  logic             adv;
  logic             out_load;
  logic             out_load_last;
  logic             last_cmp;
  logic             last_i;
  logic             last_s;
  logic             smaller;

  assign in_acc   = in_valid_i && in_ready_o;
  assign store_ok = cnt_q < CntW'(MAX_ITEMS);
  assign out_free = !out_valid_q || out_ready_i;
  assign last_cmp = j_q == cnt_q;
  assign last_i   = (CntW'(i_q) + CntW'(1)) == cnt_q;
  assign last_s   = s_q == IdxW'(MAX_ITEMS - 1);
  assign smaller  = $signed(val_rdata) < vi_q;

  rsd_ram #(
    .Width(DataW),
    .Depth(MAX_ITEMS)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(cnt_q[IdxW-1:0]),
    .wdata_i(in_data_i.sample),
    .raddr_i(val_raddr),
    .rdata_o(val_rdata)
  );

  rsd_ram #(
    .Width(DataW),
    .Depth(MAX_ITEMS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(rank_q),
    .wdata_i(vi_q),
    .raddr_i(s_q),
    .rdata_o(slot_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: begin
        if (in_acc && in_data_i.final_item) begin
          state_d = S_RDI;
        end
      end
      S_RDI:  state_d = S_LATI;
      S_LATI: state_d = S_CMP;
      S_CMP: begin
        if (last_cmp) begin
          state_d = S_WR;
        end
      end
      S_WR: begin
        state_d = last_i ? S_SRD : S_RDI;
      end
      S_SRD: begin
        if (slot_valid_q[s_q]) begin
          state_d = S_SGET;
        end else if (last_s) begin
          state_d = S_FLUSH;
        end
      end
      S_SGET: begin
        if (adv) begin
          state_d = last_s ? S_FLUSH : S_SRD;
        end
      end
      S_FLUSH: begin
        if (adv) begin
          state_d = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o    = 1'b0;
    val_we        = 1'b0;
    val_raddr     = i_q;
    slot_we       = 1'b0;
    adv           = 1'b0;
    out_load      = 1'b0;
    out_load_last = 1'b0;
    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        val_we     = in_acc && store_ok;
      end
      S_RDI:  val_raddr = i_q;
      S_LATI: val_raddr = '0;
      S_CMP:  val_raddr = j_q[IdxW-1:0];
      S_WR:   slot_we = 1'b1;
      S_SGET: begin
        // The held value goes out only once we know a larger one follows.
        adv      = !pend_v_q || out_free;
        out_load = pend_v_q && adv;
      end
      S_FLUSH: begin
        adv           = out_free;
        out_load      = adv;
        out_load_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      cnt_q        <= '0;
      i_q          <= '0;
      j_q          <= '0;
      rank_q       <= '0;
      s_q          <= '0;
      slot_valid_q <= '0;
      pend_v_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (val_we) begin
            cnt_q <= cnt_q + CntW'(1);
          end
          i_q <= '0;
        end
        S_LATI: begin
          j_q    <= CntW'(1);
          rank_q <= '0;
        end
        S_CMP: begin
          if (smaller) begin
            rank_q <= rank_q + IdxW'(1);
          end
          if (!last_cmp) begin
            j_q <= j_q + CntW'(1);
          end
        end
        S_WR: begin
          slot_valid_q[rank_q] <= 1'b1;
          i_q <= i_q + IdxW'(1);
          s_q <= '0;
        end
        S_SRD: begin
          if (!slot_valid_q[s_q] && !last_s) begin
            s_q <= s_q + IdxW'(1);
          end
        end
        S_SGET: begin
          if (adv) begin
            pend_v_q <= 1'b1;
            if (!last_s) begin
              s_q <= s_q + IdxW'(1);
            end
          end
        end
        S_FLUSH: begin
          if (adv) begin
            pend_v_q     <= 1'b0;
            cnt_q        <= '0;
            slot_valid_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_LATI) begin
      vi_q <= $signed(val_rdata);
    end
    if (state_q == S_SGET && adv) begin
      pend_q <= $signed(slot_rdata);
    end
    if (out_load) begin
      out_q.sorted_value <= pend_q;
      out_q.last_out     <= out_load_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_ITEMS))
    else $error("item count exceeds capacity");

  a_final_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.final_item) |=> !in_ready_o)
    else $error("input still ready after the final request");

  a_slots_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> (slot_valid_q == '0 && !pend_v_q))
    else $error("slot state left over from a previous set");

  a_flush_has_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH) |-> pend_v_q)
    else $error("set ended without any held result");
`endif

endmodule

### dv/tb.sv
// Testbench for rank_sort_distinct: sends sets of signed samples and checks sorted distinct output.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rsd_pkg::*;

  localparam int unsigned Cap           = rsd_pkg::MaxItemsDflt;
  localparam int unsigned TargetSamples = 480;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 50;

  // Keeps the current set, ranks it on the final request and queues the
  // distinct values it must produce, smallest first.
  class sort_scoreboard;
    int       set_samples[$];
    rsd_out_t sorted_due[$];
    int       raw_count;
    int       errors;
    int       checked;
    int       sets;
    int       overfull_sets;

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task note_request(rsd_in_t req);
      int       rank;
      int       slot_val [Cap];
      bit       occupied [Cap];
      int       top;
      rsd_out_t res;
      raw_count++;
      if (set_samples.size() < Cap) set_samples.push_back(int'(req.sample));
      if (!req.final_item) return;
      sets++;
      if (raw_count > Cap) overfull_sets++;
      foreach (occupied[s]) occupied[s] = 1'b0;
      // A sample's slot is the number of samples strictly below it, so
      // equal samples collapse into the same slot.
      foreach (set_samples[i]) begin
        rank = 0;
        foreach (set_samples[j]) begin
          if (set_samples[j] < set_samples[i]) rank++;
        end
        slot_val[rank] = set_samples[i];
        occupied[rank] = 1'b1;
      end
      top = -1;
      foreach (occupied[s]) begin
        if (occupied[s]) top = s;
      end
      foreach (occupied[s]) begin
        if (occupied[s]) begin
          res.sorted_value = 16'(slot_val[s]);
          res.last_out     = (s == top);
          sorted_due.push_back(res);
        end
      end
      set_samples.delete();
      raw_count = 0;
    endtask

    task check_result(rsd_out_t got);
      rsd_out_t want;
      if (sorted_due.size() == 0) begin
        report($sformatf("result %0d (last %0b) with nothing expected",
                         got.sorted_value, got.last_out));
        return;
      end
      want = sorted_due.pop_front();
      checked++;
      if (got.sorted_value !== want.sorted_value)
        report($sformatf("sorted_value %0d, expected %0d",
                         got.sorted_value, want.sorted_value));
      if (got.last_out !== want.last_out)
        report($sformatf("last_out %0b on value %0d, expected %0b",
                         got.last_out, want.sorted_value, want.last_out));
    endtask
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  rsd_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rsd_out_t out_data;

  sort_scoreboard sb = new();
  int  samples_sent = 0;
  int  idle_cycles  = 0;
  int  ready_hold   = 0;
  int  stall_len;
  bit  no_idle      = 1'b0;

  always #5 clk = ~clk;

  rank_sort_distinct dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // Mostly short gaps, sometimes long ones, none while no_idle is set.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready) begin
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_ready  <= 1'b0;
        ready_hold <= stall_len - 1;
      end
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 30);
    end
  end

  initial begin
    wait (idle_cycles >= WatchdogLimit);
    $display("watchdog: no request or result moved for %0d cycles", WatchdogLimit);
    $display("tb failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_sample(input int value, input bit fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= '{sample: 16'(value), final_item: fin};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    @(negedge clk);
  endtask

  // Called at a falling edge right after the last accepted request.
  task automatic wait_all_sorted();
    in_valid <= 1'b0;
    while (sb.sorted_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int  set_len;
    int  mode;
    int  v;
    bit  paused;
    paused = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed sets: single samples of the largest value and of -1, -1 among duplicates,
    // an all-equal pair, and a set that overflows so the final sample drops.
    send_sample(32767, 1'b1);
    send_sample(-1, 1'b1);
    send_sample(-32768, 1'b0);
    send_sample(32767, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b1);
    send_sample(7, 1'b0);
    send_sample(7, 1'b1);
    for (int i = 0; i < Cap; i++) send_sample(7000 - i * 900, 1'b0);
    send_sample(-32768, 1'b1);

    while (samples_sent < TargetSamples) begin
      no_idle = ($urandom_range(0, 99) < 20);
      mode    = $urandom_range(0, 2);
      case ($urandom_range(0, 19))
        0:             set_len = 1;
        1, 2, 3:       set_len = Cap;
        4, 5:          set_len = $urandom_range(Cap + 1, Cap + 6);
        default:       set_len = $urandom_range(2, Cap);
      endcase
      for (int k = 0; k < set_len; k++) begin
        case (mode)
          0:       v = int'($signed(16'($urandom)));
          1:       v = int'($urandom_range(0, 8)) - 4;
          default: begin
            case ($urandom_range(0, 5))
              0:       v = -32768;
              1:       v = -32767;
              2:       v = 32767;
              3:       v = 32766;
              4:       v = -1;
              default: v = 0;
            endcase
          end
        endcase
        send_sample(v, k == set_len - 1);
      end
      // Hold off once until the block has handed over every result.
      if (!paused && samples_sent > TargetSamples / 2) begin
        paused = 1'b1;
        wait_all_sorted();
      end
    end
    no_idle  = 1'b0;
    in_valid <= 1'b0;

    wait_all_sorted();
    repeat (DrainCycles) @(posedge clk);
    if (sb.sorted_due.size() != 0)
      sb.report($sformatf("%0d sorted results never arrived", sb.sorted_due.size()));

    $display("Sent %0d samples in %0d sets, %0d of them over capacity.",
             samples_sent, sb.sets, sb.overfull_sets);
    $display("Checked %0d sorted results, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### rank_sort_distinct.f
src/rsd_pkg.sv
src/rsd_ram.sv
src/rank_sort_distinct.sv
dv/tb.sv
